/* hw/rtl/atrk_pkg.sv */
package atrk_pkg;

  // Default sizing of the table.
  localparam int SLOTS_DEF     = 64;
  localparam int ADDR_BITS_DEF = 48;
  localparam int SIZE_BITS_DEF = 32;

  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;

  // Action codes carried in the input tuser.
  localparam logic [ACTION_W-1:0] ACT_ADD      = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_UPDATE   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_OWNS     = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_CONDENSE = 3'd5;

  // Status codes carried in the output tuser.
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_REJECT    = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_SWEEP,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                hit;
  } res_flags_t;

endpackage

/* hw/rtl/atrk_mem.sv */
module atrk_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 80,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/atrk_match.sv */
module atrk_match #(
  parameter int ADDR_BITS = 48,
  parameter int SIZE_BITS = 32
) (
  input  logic [atrk_pkg::ACTION_W-1:0] action,
  input  logic [ADDR_BITS-1:0]          key,
  input  logic [ADDR_BITS-1:0]          base,
  input  logic [SIZE_BITS-1:0]          length,
  output logic                          match
);

  localparam int CW = (ADDR_BITS > SIZE_BITS) ? ADDR_BITS : SIZE_BITS;

  logic [ADDR_BITS:0] diff;
  logic               in_range;

  // The key lies in the range when the base is nonzero, the subtraction does not
  // borrow and the offset stays below the length; this never overflows the range end.
  assign diff     = {1'b0, key} - {1'b0, base};
  assign in_range = (base != '0) && !diff[ADDR_BITS] &&
                    (CW'(diff[ADDR_BITS-1:0]) < CW'(length));

  always_comb begin
    case (action)
      atrk_pkg::ACT_ADD:    match = (base == '0);
      atrk_pkg::ACT_REMOVE,
      atrk_pkg::ACT_UPDATE,
      atrk_pkg::ACT_LOOKUP: match = (base == key);
      atrk_pkg::ACT_OWNS:   match = in_range;
      default:              match = 1'b0;
    endcase
  end

endmodule

/* hw/rtl/atrk_seq.sv */
module atrk_seq #(
  parameter int SLOTS     = 64,
  parameter int ADDR_BITS = 48,
  parameter int SIZE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [atrk_pkg::ACTION_W-1:0] in_action,
  input  logic [ADDR_BITS-1:0]          in_address,
  input  logic [ADDR_BITS-1:0]          in_new_address,
  input  logic [SIZE_BITS-1:0]          in_size,
  output logic                          res_valid,
  input  logic                          res_ready,
  output atrk_pkg::res_flags_t          res_flags,
  output logic [$clog2(SLOTS)-1:0]      res_slot,
  output logic [SIZE_BITS-1:0]          res_size,
  output logic [$clog2(SLOTS+1)-1:0]    res_live,
  output logic [SIZE_BITS+$clog2(SLOTS)-1:0] res_total
);

  localparam int IW    = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS+1);
  localparam int TOT_W = SIZE_BITS + $clog2(SLOTS);
  localparam int MW    = ADDR_BITS + SIZE_BITS;
  localparam logic [IW:0]   PTR_END  = (IW+1)'(SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS-1);

  atrk_pkg::state_t state, state_next;

  logic [IW:0]   rd_ptr;
  logic [IW:0]   wr_ptr;
  logic          chk_valid;
  logic [IW-1:0] chk_idx;

  logic [atrk_pkg::ACTION_W-1:0] op_action;
  logic [ADDR_BITS-1:0]          op_addr;
  logic [ADDR_BITS-1:0]          op_naddr;
  logic [SIZE_BITS-1:0]          op_size;

  logic [atrk_pkg::STATUS_W-1:0] res_status;
  logic                          res_hit;
  logic [CNT_W-1:0]              count;
  logic [TOT_W-1:0]              total;

  logic                          mem_we;
  logic [IW-1:0]                 mem_waddr;
  logic [MW-1:0]                 mem_wdata;
  logic [IW-1:0]                 mem_raddr;
  logic [MW-1:0]                 mem_rdata;
  logic [ADDR_BITS-1:0]          rd_base;
  logic [SIZE_BITS-1:0]          rd_len;

  logic                          hit_now;
  logic                          last;
  logic                          is_condense;
  logic                          pre_scan;
  logic [atrk_pkg::STATUS_W-1:0] pre_status;

  assign rd_base     = mem_rdata[MW-1:SIZE_BITS];
  assign rd_len      = mem_rdata[SIZE_BITS-1:0];
  assign last        = (chk_idx == LAST_IDX);
  assign is_condense = (op_action == atrk_pkg::ACT_CONDENSE);
  assign mem_raddr   = (rd_ptr < PTR_END) ? rd_ptr[IW-1:0] : '0;

  atrk_mem #(
    .DEPTH (SLOTS),
    .WIDTH (MW),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  atrk_match #(
    .ADDR_BITS (ADDR_BITS),
    .SIZE_BITS (SIZE_BITS)
  ) u_match (
    .action (op_action),
    .key    (op_addr),
    .base   (rd_base),
    .length (rd_len),
    .match  (hit_now)
  );

  // Argument checks made as the beat is taken; some actions finish here.
  always_comb begin
    pre_scan   = 1'b1;
    pre_status = atrk_pkg::STAT_OK;
    case (in_action)
      atrk_pkg::ACT_ADD: begin
        if (in_address == '0 || in_size == '0) begin
          pre_scan   = 1'b0;
          pre_status = atrk_pkg::STAT_REJECT;
        end
      end
      atrk_pkg::ACT_REMOVE: begin
        if (in_address == '0) begin
          pre_scan   = 1'b0;
          pre_status = atrk_pkg::STAT_REJECT;
        end
      end
      atrk_pkg::ACT_UPDATE: begin
        if (in_address == '0 || in_new_address == '0 || in_size == '0) begin
          pre_scan   = 1'b0;
          pre_status = atrk_pkg::STAT_REJECT;
        end
      end
      atrk_pkg::ACT_LOOKUP: begin
        if (in_address == '0) begin
          pre_scan   = 1'b0;
          pre_status = atrk_pkg::STAT_NOT_FOUND;
        end
      end
      atrk_pkg::ACT_OWNS:     pre_status = atrk_pkg::STAT_NOT_FOUND;
      atrk_pkg::ACT_CONDENSE: pre_status = atrk_pkg::STAT_OK;
      default:                pre_scan   = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      atrk_pkg::S_CLEAR: begin
        if (wr_ptr == PTR_END) state_next = atrk_pkg::S_IDLE;
      end
      atrk_pkg::S_IDLE: begin
        if (in_valid) state_next = pre_scan ? atrk_pkg::S_SCAN : atrk_pkg::S_RESP;
      end
      atrk_pkg::S_SCAN: begin
        if (chk_valid) begin
          if (is_condense) begin
            if (last) state_next = atrk_pkg::S_SWEEP;
          end else if (hit_now || last) begin
            state_next = atrk_pkg::S_RESP;
          end
        end
      end
      atrk_pkg::S_SWEEP: begin
        if (wr_ptr == PTR_END) state_next = atrk_pkg::S_RESP;
      end
      atrk_pkg::S_RESP: begin
        if (res_ready) state_next = atrk_pkg::S_IDLE;
      end
      default: state_next = atrk_pkg::S_IDLE;
    endcase
  end

  // Table write port: clearing sweeps, condense moves and the single
  // write-back of a matched or free slot.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_ptr[IW-1:0];
    mem_wdata = '0;
    case (state)
      atrk_pkg::S_CLEAR, atrk_pkg::S_SWEEP: begin
        if (wr_ptr != PTR_END) mem_we = 1'b1;
      end
      atrk_pkg::S_SCAN: begin
        if (chk_valid) begin
          if (is_condense) begin
            if (rd_base != '0) begin
              mem_we    = 1'b1;
              mem_wdata = mem_rdata;
            end
          end else if (hit_now) begin
            mem_waddr = chk_idx;
            case (op_action)
              atrk_pkg::ACT_ADD: begin
                mem_we    = 1'b1;
                mem_wdata = {op_addr, op_size};
              end
              atrk_pkg::ACT_REMOVE: mem_we = 1'b1;
              atrk_pkg::ACT_UPDATE: begin
                mem_we    = 1'b1;
                mem_wdata = {op_naddr, op_size};
              end
              default: mem_we = 1'b0;
            endcase
          end
        end
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= atrk_pkg::S_CLEAR;
      wr_ptr    <= '0;
      chk_valid <= 1'b0;
      count     <= '0;
      total     <= '0;
    end else begin
      state     <= state_next;
      chk_valid <= (state == atrk_pkg::S_SCAN) && (rd_ptr < PTR_END);
      case (state)
        atrk_pkg::S_CLEAR, atrk_pkg::S_SWEEP: begin
          if (wr_ptr != PTR_END) wr_ptr <= wr_ptr + 1'b1;
        end
        atrk_pkg::S_IDLE: begin
          if (in_valid) wr_ptr <= '0;
        end
        atrk_pkg::S_SCAN: begin
          if (chk_valid) begin
            if (is_condense) begin
              if (rd_base != '0) wr_ptr <= wr_ptr + 1'b1;
            end else if (hit_now) begin
              case (op_action)
                atrk_pkg::ACT_ADD: begin
                  count <= count + 1'b1;
                  total <= total + TOT_W'(op_size);
                end
                atrk_pkg::ACT_REMOVE: begin
                  count <= count - 1'b1;
                  total <= total - TOT_W'(rd_len);
                end
                atrk_pkg::ACT_UPDATE: total <= total - TOT_W'(rd_len) + TOT_W'(op_size);
                default: count <= count;
              endcase
            end
          end
        end
        default: wr_ptr <= wr_ptr;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= rd_ptr[IW-1:0];
    case (state)
      atrk_pkg::S_IDLE: begin
        if (in_valid) begin
          op_action  <= in_action;
          op_addr    <= in_address;
          op_naddr   <= in_new_address;
          op_size    <= in_size;
          rd_ptr     <= '0;
          res_status <= pre_status;
          res_hit    <= 1'b0;
          res_slot   <= '0;
          res_size   <= '0;
        end
      end
      atrk_pkg::S_SCAN: begin
        if (rd_ptr < PTR_END) rd_ptr <= rd_ptr + 1'b1;
        if (chk_valid && !is_condense) begin
          if (hit_now) begin
            res_status <= atrk_pkg::STAT_OK;
            res_hit    <= (op_action != atrk_pkg::ACT_ADD);
            res_slot   <= chk_idx;
            if (op_action == atrk_pkg::ACT_LOOKUP) res_size <= rd_len;
          end else if (last) begin
            res_status <= (op_action == atrk_pkg::ACT_ADD) ? atrk_pkg::STAT_FULL
                                                           : atrk_pkg::STAT_NOT_FOUND;
          end
        end
      end
      default: rd_ptr <= rd_ptr;
    endcase
  end

  assign in_ready         = (state == atrk_pkg::S_IDLE);
  assign res_valid        = (state == atrk_pkg::S_RESP);
  assign res_flags.status = res_status;
  assign res_flags.hit    = res_hit;
  assign res_live         = count;
  assign res_total        = total;

endmodule

/* hw/rtl/allocation_tracking_table_core.sv */
// Channel  Dir  Handshake      tuser   tdata, lowest bit first
// s_axis   in   tvalid/tready  action  address, new_address, size
// m_axis   out  tvalid/tready  status  hit, slot_index, size_out, live_entries, total_bytes
//
// Every action that passes its argument checks walks the table one slot per cycle through
// the single read port and stops at the first matching slot, or after the last slot on
// a miss or a full table. Condense reads every slot and then zeroes the freed tail;
// actions rejected on their arguments skip the walk and go straight to the result.
// After reset the table is cleared before s_axis_tready rises.
// While a result waits in the output register one more action can be taken and worked.
module allocation_tracking_table_core #(
  parameter int SLOTS     = atrk_pkg::SLOTS_DEF,
  parameter int ADDR_BITS = atrk_pkg::ADDR_BITS_DEF,
  parameter int SIZE_BITS = atrk_pkg::SIZE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,

  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata, lowest bit first: address, new_address, size, zero fill.
  input  logic [((2*ADDR_BITS+SIZE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tuser: action.
  input  logic [atrk_pkg::ACTION_W-1:0]          s_axis_tuser,

  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // tdata, lowest bit first: hit, slot_index, size_out, live_entries,
  // total_bytes, zero fill.
  output logic [((1+$clog2(SLOTS)+SIZE_BITS+$clog2(SLOTS+1)+SIZE_BITS+$clog2(SLOTS)+7)/8)*8-1:0]
                                                 m_axis_tdata,
  // tuser: status.
  output logic [atrk_pkg::STATUS_W-1:0]          m_axis_tuser
);

  localparam int IW    = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS+1);
  localparam int TOT_W = SIZE_BITS + $clog2(SLOTS);
  localparam int OUT_W = ((1+IW+SIZE_BITS+CNT_W+TOT_W+7)/8)*8;

  logic                 res_valid;
  logic                 res_ready;
  atrk_pkg::res_flags_t res_flags;
  logic [IW-1:0]        res_slot;
  logic [SIZE_BITS-1:0] res_size;
  logic [CNT_W-1:0]     res_live;
  logic [TOT_W-1:0]     res_total;

  // The sequencer owns the table and all of the scanning; this level only
  // unpacks the input beat and holds the result beat.
  atrk_seq #(
    .SLOTS     (SLOTS),
    .ADDR_BITS (ADDR_BITS),
    .SIZE_BITS (SIZE_BITS)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .in_action      (s_axis_tuser),
    .in_address     (s_axis_tdata[ADDR_BITS-1:0]),
    .in_new_address (s_axis_tdata[2*ADDR_BITS-1:ADDR_BITS]),
    .in_size        (s_axis_tdata[2*ADDR_BITS+SIZE_BITS-1:2*ADDR_BITS]),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res_flags      (res_flags),
    .res_slot       (res_slot),
    .res_size       (res_size),
    .res_live       (res_live),
    .res_total      (res_total)
  );

  // The output register takes a new result when it is empty or its beat is
  // being taken in the same cycle.
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tuser <= res_flags.status;
      m_axis_tdata <= OUT_W'({res_total, res_live, res_size, res_slot, res_flags.hit});
    end
  end

endmodule
